### rtl/core/pci_pkg.sv
// ============================================================================
// pci_pkg: shared types for the power calibration interpolator
// Operation codes, the boundary read select, and the command and status
// structs that join the controller to the datapath.
// ============================================================================
package pci_pkg;

  // Width of one calibration word and of each output level.
  localparam int LEVEL_W = 16;
  // Quotient bits kept from the interpolation divide.
  localparam int QW = 17;

  // Operation carried by an input beat.
  typedef enum logic [1:0] {
    OP_WR_BND  = 2'd0,
    OP_WR_HIGH = 2'd1,
    OP_WR_LOW  = 2'd2,
    OP_QUERY   = 2'd3
  } op_t;

  // Which boundary entry the datapath reads.
  typedef enum logic [1:0] {
    BSEL_B1  = 2'd0,
    BSEL_S   = 2'd1,
    BSEL_SM1 = 2'd2
  } bnd_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     accept;
    bnd_sel_t bnd_sel;
    logic     cal_hi;
    logic     chk_b1;
    logic     chk_s;
    logic     cap_lo;
    logic     cap_hi;
    logic     setup;
    logic     mul;
    logic     div_step;
    logic     finish;
  } pci_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic f_le;
    logic s_last;
    logic flat;
    logic div_done;
    logic out_free;
  } pci_sts_t;

endpackage

### rtl/core/pci_ctrl.sv
// ============================================================================
// pci_ctrl: query sequencer
// One-hot state machine that accepts beats, walks the boundary search, the
// calibration word fetches, the multiply and the serial divide, and hands
// the result to the output register.
// ============================================================================
module pci_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_op,
  output logic              in_ready,
  output pci_pkg::pci_cmd_t cmd,
  input  pci_pkg::pci_sts_t sts
);

  typedef enum logic [11:0] {
    ST_IDLE   = 12'b0000_0000_0001,
    ST_RD_B1  = 12'b0000_0000_0010,
    ST_CHK_B1 = 12'b0000_0000_0100,
    ST_RD_BS  = 12'b0000_0000_1000,
    ST_CHK_BS = 12'b0000_0001_0000,
    ST_RD_LO  = 12'b0000_0010_0000,
    ST_CAP_LO = 12'b0000_0100_0000,
    ST_CAP_HI = 12'b0000_1000_0000,
    ST_SETUP  = 12'b0001_0000_0000,
    ST_MUL    = 12'b0010_0000_0000,
    ST_DIV    = 12'b0100_0000_0000,
    ST_FIN    = 12'b1000_0000_0000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // Next state and per-state commands.
  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.bnd_sel  = pci_pkg::BSEL_S;
    cmd.accept   = accept;
    case (state_r)
      ST_IDLE: begin
        if (accept && (pci_pkg::op_t'(in_op) == pci_pkg::OP_QUERY)) begin
          state_nxt = ST_RD_B1;
        end
      end
      ST_RD_B1: begin
        cmd.bnd_sel = pci_pkg::BSEL_B1;
        state_nxt   = ST_CHK_B1;
      end
      ST_CHK_B1: begin
        cmd.chk_b1 = 1'b1;
        state_nxt  = ST_RD_BS;
      end
      ST_RD_BS: begin
        state_nxt = ST_CHK_BS;
      end
      ST_CHK_BS: begin
        cmd.chk_s = 1'b1;
        if (sts.f_le || sts.s_last) begin
          state_nxt = ST_RD_LO;
        end else begin
          state_nxt = ST_RD_BS;
        end
      end
      ST_RD_LO: begin
        cmd.bnd_sel = pci_pkg::BSEL_SM1;
        state_nxt   = ST_CAP_LO;
      end
      ST_CAP_LO: begin
        cmd.cap_lo = 1'b1;
        cmd.cal_hi = 1'b1;
        if (sts.flat) begin
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_CAP_HI;
        end
      end
      ST_CAP_HI: begin
        cmd.cap_hi = 1'b1;
        state_nxt  = ST_SETUP;
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (sts.div_done) begin
          state_nxt = ST_FIN;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### rtl/core/pci_dp.sv
// ============================================================================
// pci_dp: interpolator datapath
// Boundary and calibration word memories, sector counter, one multiplier
// pair, two restoring dividers that share the divisor, rounding and the
// output register.
// ============================================================================
module pci_dp #(
  parameter int CAL_POINTS = 8,
  parameter int FREQ_BITS  = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pci_pkg::pci_cmd_t cmd,
  output pci_pkg::pci_sts_t sts,
  input  logic [1:0]        in_op,
  input  logic [3:0]        in_index,
  input  logic [31:0]       in_value,
  input  logic [31:0]       in_freq,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [15:0]       out_high_level,
  output logic [15:0]       out_low_level,
  output logic [15:0]       out_mid_level
);

  localparam int NUM_BOUNDS = CAL_POINTS + 2;
  localparam int BW         = (FREQ_BITS < 32) ? FREQ_BITS : 32;
  localparam int SW         = $clog2(NUM_BOUNDS);
  localparam int CW         = $clog2(CAL_POINTS);
  localparam int LW         = pci_pkg::LEVEL_W;
  localparam int QW         = pci_pkg::QW;
  localparam int NB         = BW + LW;
  localparam int KW         = $clog2(NB + 1);

  // Rounded level: w0 plus or minus q, rounding half up, clamped to 16 bits.
  function automatic logic [LW-1:0] round_level(
    input logic [LW-1:0] w0,
    input logic          neg,
    input logic [QW-1:0] q,
    input logic [BW-1:0] rem,
    input logic [BW-1:0] den
  );
    logic [BW:0]   two_r;
    logic          inc;
    logic [QW:0]   qr;
    logic [QW+1:0] sum;
    logic [LW-1:0] res;
    two_r = {rem, 1'b0};
    inc   = neg ? (two_r > {1'b0, den}) : (two_r >= {1'b0, den});
    qr    = {1'b0, q} + (QW + 1)'(inc);
    if (!neg) begin
      sum = {{(QW + 2 - LW){1'b0}}, w0} + {1'b0, qr};
      res = (sum > (QW + 2)'({LW{1'b1}})) ? {LW{1'b1}} : sum[LW-1:0];
    end else begin
      sum = {{(QW + 2 - LW){1'b0}}, w0} - {1'b0, qr};
      res = sum[QW+1] ? {LW{1'b0}} : sum[LW-1:0];
    end
    return res;
  endfunction

  // Table storage.
  logic [BW-1:0] bnd_mem  [NUM_BOUNDS];
  logic [LW-1:0] high_mem [CAL_POINTS];
  logic [LW-1:0] low_mem  [CAL_POINTS];

  logic [BW-1:0] bnd_rd_r;
  logic [LW-1:0] high_rd_r;
  logic [LW-1:0] low_rd_r;

  // Query registers.
  logic [BW-1:0] freq_r;
  logic [SW-1:0] s_r;
  logic          le_b1_r;
  logic          flat_r;
  logic [BW-1:0] bnd_hi_r;
  logic [BW-1:0] bnd_lo_r;
  logic [LW-1:0] w0h_r;
  logic [LW-1:0] w0l_r;
  logic [LW-1:0] w1h_r;
  logic [LW-1:0] w1l_r;
  logic [BW-1:0] d_r;
  logic [BW-1:0] den_r;
  logic [LW-1:0] magh_r;
  logic [LW-1:0] magl_r;
  logic          negh_r;
  logic          negl_r;
  logic [NB-1:0] nh_r;
  logic [NB-1:0] nl_r;
  logic [BW-1:0] rh_r;
  logic [BW-1:0] rl_r;
  logic [KW-1:0] cnt_r;

  // Output register.
  logic          out_valid_r;
  logic [LW-1:0] out_high_r;
  logic [LW-1:0] out_low_r;
  logic [LW-1:0] out_mid_r;

  // Write and read addresses.
  logic [SW+3:0] bidx_ext;
  logic [CW+3:0] cidx_ext;
  logic          bnd_we;
  logic          high_we;
  logic          low_we;
  logic [SW-1:0] bnd_ra;
  logic [SW-1:0] s_m1;
  logic [SW-1:0] s_m2;
  logic [CW-1:0] cal_ra;
  pci_pkg::op_t  op;

  assign op       = pci_pkg::op_t'(in_op);
  assign bidx_ext = (SW + 4)'(in_index);
  assign cidx_ext = (CW + 4)'(in_index);
  assign bnd_we   = cmd.accept && (op == pci_pkg::OP_WR_BND)
                    && (32'(in_index) < 32'(NUM_BOUNDS));
  assign high_we  = cmd.accept && (op == pci_pkg::OP_WR_HIGH)
                    && (32'(in_index) < 32'(CAL_POINTS));
  assign low_we   = cmd.accept && (op == pci_pkg::OP_WR_LOW)
                    && (32'(in_index) < 32'(CAL_POINTS));
  assign s_m1     = s_r - SW'(1);
  assign s_m2     = s_r - SW'(2);
  assign cal_ra   = (cmd.cal_hi && !flat_r) ? s_m1[CW-1:0] : s_m2[CW-1:0];

  always_comb begin
    case (cmd.bnd_sel)
      pci_pkg::BSEL_B1:  bnd_ra = SW'(1);
      pci_pkg::BSEL_SM1: bnd_ra = s_m1;
      default:           bnd_ra = s_r;
    endcase
  end

  // Memories: one write port from loads, one registered read port each.
  always_ff @(posedge clk) begin
    if (bnd_we) begin
      bnd_mem[bidx_ext[SW-1:0]] <= in_value[BW-1:0];
    end
    if (high_we) begin
      high_mem[cidx_ext[CW-1:0]] <= in_value[LW-1:0];
    end
    if (low_we) begin
      low_mem[cidx_ext[CW-1:0]] <= in_value[LW-1:0];
    end
    bnd_rd_r  <= bnd_mem[bnd_ra];
    high_rd_r <= high_mem[cal_ra];
    low_rd_r  <= low_mem[cal_ra];
  end

  // Status toward the controller.
  logic f_le;
  assign f_le         = (freq_r <= bnd_rd_r);
  assign sts.f_le     = f_le;
  assign sts.s_last   = (s_r == SW'(CAL_POINTS));
  assign sts.flat     = flat_r;
  assign sts.div_done = (cnt_r == '0);
  assign sts.out_free = !out_valid_r || out_ready;

  // Products of offset and word difference.
  logic [NB-1:0] prod_h;
  logic [NB-1:0] prod_l;
  assign prod_h = d_r * magh_r;
  assign prod_l = d_r * magl_r;

  // One restoring divide step for each level, shared divisor.
  logic [BW:0]   remsh_h;
  logic [BW:0]   remsh_l;
  logic [BW:0]   diff_h;
  logic [BW:0]   diff_l;
  logic          ge_h;
  logic          ge_l;
  logic [BW-1:0] rh_nxt;
  logic [BW-1:0] rl_nxt;
  logic [NB-1:0] nh_nxt;
  logic [NB-1:0] nl_nxt;

  assign remsh_h = {rh_r, nh_r[NB-1]};
  assign remsh_l = {rl_r, nl_r[NB-1]};
  assign ge_h    = (remsh_h >= {1'b0, den_r});
  assign ge_l    = (remsh_l >= {1'b0, den_r});
  assign diff_h  = remsh_h - {1'b0, den_r};
  assign diff_l  = remsh_l - {1'b0, den_r};
  assign rh_nxt  = ge_h ? diff_h[BW-1:0] : remsh_h[BW-1:0];
  assign rl_nxt  = ge_l ? diff_l[BW-1:0] : remsh_l[BW-1:0];
  assign nh_nxt  = {nh_r[NB-2:0], ge_h};
  assign nl_nxt  = {nl_r[NB-2:0], ge_l};

  // Final levels.
  logic [LW-1:0] lvl_h;
  logic [LW-1:0] lvl_l;
  logic [LW:0]   lvl_sum;
  assign lvl_h   = flat_r ? w0h_r : round_level(w0h_r, negh_r, nh_r[QW-1:0], rh_r, den_r);
  assign lvl_l   = flat_r ? w0l_r : round_level(w0l_r, negl_r, nl_r[QW-1:0], rl_r, den_r);
  assign lvl_sum = {1'b0, lvl_h} + {1'b0, lvl_l};

  // Query datapath registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      freq_r <= in_freq[BW-1:0];
      s_r    <= SW'(2);
    end
    if (cmd.chk_b1) begin
      le_b1_r <= f_le;
    end
    if (cmd.chk_s) begin
      if (f_le) begin
        bnd_hi_r <= bnd_rd_r;
        flat_r   <= le_b1_r;
      end else begin
        s_r    <= s_r + SW'(1);
        flat_r <= 1'b1;
      end
    end
    if (cmd.cap_lo) begin
      bnd_lo_r <= bnd_rd_r;
      w0h_r    <= high_rd_r;
      w0l_r    <= low_rd_r;
    end
    if (cmd.cap_hi) begin
      w1h_r <= high_rd_r;
      w1l_r <= low_rd_r;
    end
    if (cmd.setup) begin
      d_r    <= freq_r - bnd_lo_r;
      den_r  <= bnd_hi_r - bnd_lo_r;
      negh_r <= (w1h_r < w0h_r);
      negl_r <= (w1l_r < w0l_r);
      magh_r <= (w1h_r < w0h_r) ? (w0h_r - w1h_r) : (w1h_r - w0h_r);
      magl_r <= (w1l_r < w0l_r) ? (w0l_r - w1l_r) : (w1l_r - w0l_r);
    end
    if (cmd.mul) begin
      nh_r <= prod_h;
      nl_r <= prod_l;
      rh_r <= '0;
      rl_r <= '0;
    end
    if (cmd.div_step) begin
      nh_r <= nh_nxt;
      nl_r <= nl_nxt;
      rh_r <= rh_nxt;
      rl_r <= rl_nxt;
    end
    if (cmd.finish) begin
      out_high_r <= lvl_h;
      out_low_r  <= lvl_l;
      out_mid_r  <= lvl_sum[LW:1];
    end
  end

  // Divide step counter and output valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.mul) begin
        cnt_r <= KW'(NB);
      end else if (cmd.div_step) begin
        cnt_r <= cnt_r - KW'(1);
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_high_level = out_high_r;
  assign out_low_level  = out_low_r;
  assign out_mid_level  = out_mid_r;

endmodule

### rtl/core/power_cal_interpolator.sv
// ============================================================================
// power_cal_interpolator: piecewise linear power calibration lookup
// Loads fill a boundary table and two calibration word tables; a query finds
// its sector and interpolates the high and low power levels.
// ============================================================================
// A query runs a sector search of at most CAL_POINTS-1 steps; unless the
// level is flat it then multiplies and runs the serial divider for
// NB = min(FREQ_BITS,32)+16 steps. One query is in flight at a time and no
// beat is taken until it finishes; each search step reads one boundary
// entry in a read state and compares it in a check state.
// Reset clears the sequencer and the output valid flag; tables hold no reset.
module power_cal_interpolator #(
  parameter int CAL_POINTS = 8,
  parameter int FREQ_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [3:0]  in_index,
  input  logic [31:0] in_value,
  input  logic [31:0] in_freq,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_high_level,
  output logic [15:0] out_low_level,
  output logic [15:0] out_mid_level
);

  pci_pkg::pci_cmd_t cmd;
  pci_pkg::pci_sts_t sts;

  // Sequencer.
  pci_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_op),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Tables, arithmetic and output register.
  pci_dp #(
    .CAL_POINTS (CAL_POINTS),
    .FREQ_BITS  (FREQ_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_op          (in_op),
    .in_index       (in_index),
    .in_value       (in_value),
    .in_freq        (in_freq),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_high_level (out_high_level),
    .out_low_level  (out_low_level),
    .out_mid_level  (out_mid_level)
  );

endmodule

### tb/sv/tb.sv
// ============================================================================
// tb: power calibration interpolator testbench
// Loads the boundary and calibration tables, sends lookup beats, and checks
// each returned level set against a cycle-free predictor of the lookup.
// Both channels idle and stall at random, with stretches of full throughput.
// ============================================================================
module tb;

  localparam int BND_N        = 10;
  localparam int CAL_N        = 8;
  localparam int RANDOM_ITEMS = 1550;
  localparam int MAX_WAIT     = 18;
  localparam int TAIL_CYCLES  = 100;
  localparam int RUN_LIMIT    = 900000;

  typedef struct packed {
    logic [15:0] hi_lvl;
    logic [15:0] lo_lvl;
    logic [15:0] mid_lvl;
  } level_set_t;

  logic         clk      = 1'b0;
  logic         rst_n    = 1'b0;
  logic         in_valid = 1'b0;
  logic         in_ready;
  pci_pkg::op_t in_op    = pci_pkg::OP_QUERY;
  logic [3:0]   in_index = '0;
  logic [31:0]  in_value = '0;
  logic [31:0]  in_freq  = '0;
  logic         out_valid;
  logic         out_ready = 1'b0;
  logic [15:0]  out_high_level;
  logic [15:0]  out_low_level;
  logic [15:0]  out_mid_level;

  // Shadow copy of the block's tables.
  logic [31:0] bnd_mem  [BND_N];
  logic [15:0] hi_words [CAL_N];
  logic [15:0] lo_words [CAL_N];

  // Level sets still owed by the block, oldest first.
  level_set_t levels_due [$];

  int err_cnt       = 0;
  int loads_done    = 0;
  int loads_dropped = 0;
  int queries_done  = 0;
  int results_seen  = 0;
  int cycle_cnt     = 0;
  bit idle_on       = 1'b1;

  power_cal_interpolator dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_index       (in_index),
    .in_value       (in_value),
    .in_freq        (in_freq),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_high_level (out_high_level),
    .out_low_level  (out_low_level),
    .out_mid_level  (out_mid_level)
  );

  always #6 clk = ~clk;

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == RUN_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_cnt);
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic report_mismatch(string msg);
    err_cnt++;
    $display("cycle %0d: %s", cycle_cnt, msg);
  endtask

  // Per-beat wait for either side; zero whenever idling is switched off.
  function automatic int draw_wait();
    if (!idle_on) return 0;
    return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, MAX_WAIT);
  endfunction

  // Exact linear step from w0 toward w1 by d/span, rounded half up.
  function automatic logic [15:0] interp_word(logic [15:0] w0, logic [15:0] w1,
                                              logic [31:0] d, logic [31:0] span);
    logic [63:0] prod;
    logic [63:0] quo;
    logic [63:0] rem;
    logic [63:0] den;
    logic [15:0] mag;
    int          lvl;
    den  = {32'b0, span};
    mag  = (w1 >= w0) ? w1 - w0 : w0 - w1;
    prod = {32'b0, d} * {48'b0, mag};
    quo  = prod / den;
    rem  = prod % den;
    if (w1 >= w0) begin
      if (rem >= den - rem) quo = quo + 1;
      lvl = int'(w0) + int'(quo[16:0]);
    end else begin
      if (rem > den - rem) quo = quo + 1;
      lvl = int'(w0) - int'(quo[16:0]);
    end
    if (lvl < 0) lvl = 0;
    if (lvl > 65535) lvl = 65535;
    return lvl[15:0];
  endfunction

  // Sector search, then either a flat level or an interpolated one.
  function automatic level_set_t predict_levels(logic [31:0] fq);
    level_set_t  res;
    int          s;
    logic [16:0] sum;
    s = 2;
    while (s <= CAL_N && fq > bnd_mem[s]) s++;
    if (s == CAL_N + 1 || fq <= bnd_mem[1]) begin
      res.hi_lvl = hi_words[s-2];
      res.lo_lvl = lo_words[s-2];
    end else begin
      res.hi_lvl = interp_word(hi_words[s-2], hi_words[s-1], fq - bnd_mem[s-1],
                               bnd_mem[s] - bnd_mem[s-1]);
      res.lo_lvl = interp_word(lo_words[s-2], lo_words[s-1], fq - bnd_mem[s-1],
                               bnd_mem[s] - bnd_mem[s-1]);
    end
    sum = {1'b0, res.hi_lvl} + {1'b0, res.lo_lvl};
    res.mid_lvl = sum[16:1];
    return res;
  endfunction

  // Update the shadow tables, or queue the level set a lookup must return.
  task automatic apply_beat(pci_pkg::op_t op, logic [3:0] idx, logic [31:0] val,
                            logic [31:0] fq);
    case (op)
      pci_pkg::OP_WR_BND: begin
        if (idx < BND_N) begin
          bnd_mem[idx] = val;
          loads_done++;
        end else begin
          loads_dropped++;
        end
      end
      pci_pkg::OP_WR_HIGH, pci_pkg::OP_WR_LOW: begin
        if (idx < CAL_N) begin
          if (op == pci_pkg::OP_WR_HIGH) hi_words[idx] = val[15:0];
          else lo_words[idx] = val[15:0];
          loads_done++;
        end else begin
          loads_dropped++;
        end
      end
      default: begin
        levels_due.push_back(predict_levels(fq));
        queries_done++;
      end
    endcase
  endtask

  // Present one beat and hold it until the block takes it.
  task automatic send_beat(pci_pkg::op_t op, logic [3:0] idx, logic [31:0] val,
                           logic [31:0] fq);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_index <= idx;
    in_value <= val;
    in_freq  <= fq;
    do @(posedge clk); while (in_ready !== 1'b1);
    apply_beat(op, idx, val, fq);
  endtask

  // Sender holds off until every owed result has come back.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (levels_due.size() != 0);
  endtask

  // Compare one accepted result beat with the oldest owed level set.
  task automatic check_levels();
    level_set_t want;
    results_seen++;
    if (levels_due.size() == 0) begin
      report_mismatch($sformatf("result %h/%h/%h with no lookup pending",
                                out_high_level, out_low_level, out_mid_level));
      return;
    end
    want = levels_due.pop_front();
    if (out_high_level !== want.hi_lvl)
      report_mismatch($sformatf("high level %h, predicted %h", out_high_level, want.hi_lvl));
    if (out_low_level !== want.lo_lvl)
      report_mismatch($sformatf("low level %h, predicted %h", out_low_level, want.lo_lvl));
    if (out_mid_level !== want.mid_lvl)
      report_mismatch($sformatf("mid level %h, predicted %h", out_mid_level, want.mid_lvl));
  endtask

  // Result side: stall a random number of cycles per beat, then take it.
  initial begin : result_sink
    int stall;
    @(posedge clk iff rst_n === 1'b1);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      check_levels();
    end
  end

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Lookup frequencies aimed mostly at and around the stored boundaries.
  function automatic logic [31:0] pick_freq();
    int          k;
    logic [31:0] base;
    k    = $urandom_range(0, BND_N - 1);
    base = bnd_mem[k];
    case ($urandom_range(0, 5))
      0: return base;
      1: return base + 1;
      2: return base - 1;
      3: return base + $urandom_range(0, 15);
      4: return $urandom;
      default: begin
        if (k < BND_N - 1 && bnd_mem[k+1] > base)
          return base + $urandom_range(0, bnd_mem[k+1] - base);
        return $urandom;
      end
    endcase
  endfunction

  // Fill all three tables with known words; the high bits of each calibration word are junk.
  task automatic test_table_load();
    logic [31:0] bnd_pts [BND_N];
    logic [15:0] hi_pts  [CAL_N];
    bnd_pts = '{32'd0, 32'd1000, 32'd1002, 32'd5000, 32'd5001, 32'd100000,
                32'h8000_0000, 32'hFFFF_FFF0, 32'hFFFF_FFFE, 32'hFFFF_FFFF};
    hi_pts  = '{16'h0000, 16'hFFFF, 16'h0003, 16'h8000, 16'h0007, 16'hFFFF,
                16'h0000, 16'h1234};
    for (int k = 0; k < BND_N; k++)
      send_beat(pci_pkg::OP_WR_BND, 4'(k), bnd_pts[k], $urandom);
    for (int k = 0; k < CAL_N; k++) begin
      send_beat(pci_pkg::OP_WR_HIGH, 4'(k), {16'hA5A5, hi_pts[k]}, $urandom);
      send_beat(pci_pkg::OP_WR_LOW, 4'(k), {16'h5A5A, ~hi_pts[k]}, $urandom);
    end
  endtask

  // Below the first boundary, exact half steps both ways, unit spans, the
  // widest spans, and above the last boundary.
  task automatic test_sector_edges();
    logic [31:0] freqs [12];
    freqs = '{32'd0, 32'd1000, 32'd1001, 32'd1002, 32'd1003, 32'd5001, 32'd50000,
              32'h7FFF_FFFF, 32'h9000_0000, 32'hFFFF_FFF8, 32'hFFFF_FFFE, 32'hFFFF_FFFF};
    foreach (freqs[k]) send_beat(pci_pkg::OP_QUERY, 4'($urandom), $urandom, freqs[k]);
  endtask

  // Loads past the end of a table must leave it untouched.
  task automatic test_ignored_loads();
    send_beat(pci_pkg::OP_WR_BND, 4'd10, 32'd0, $urandom);
    send_beat(pci_pkg::OP_WR_BND, 4'd15, 32'hFFFF_FFFF, $urandom);
    send_beat(pci_pkg::OP_WR_HIGH, 4'd8, 32'h0000_0000, $urandom);
    send_beat(pci_pkg::OP_WR_LOW, 4'd15, 32'hFFFF_FFFF, $urandom);
    send_beat(pci_pkg::OP_WR_HIGH, 4'd12, 32'h0000_FFFF, $urandom);
    send_beat(pci_pkg::OP_QUERY, 4'd0, $urandom, 32'd1001);
    send_beat(pci_pkg::OP_QUERY, 4'd15, $urandom, 32'hFFFF_FFFF);
  endtask

  // Drain fully once, then run loads and lookups back to back.
  task automatic test_drain_pause();
    for (int k = 0; k < 3; k++)
      send_beat(pci_pkg::OP_QUERY, 4'($urandom), $urandom, pick_freq());
    wait_for_results();
    idle_on = 1'b0;
    for (int k = 0; k < 6; k++) begin
      send_beat(pci_pkg::OP_WR_HIGH, 4'($urandom_range(0, CAL_N - 1)), $urandom,
                $urandom);
      send_beat(pci_pkg::OP_QUERY, 4'($urandom), $urandom, pick_freq());
    end
    idle_on = 1'b1;
  endtask

  // Rewrite all boundaries with non-negative steps at one of several scales; from a random start the sum may wrap.
  task automatic load_ascending_bounds();
    int          sh;
    logic [31:0] b;
    case ($urandom_range(0, 4))
      0: sh = 0;
      1: sh = 2;
      2: sh = 8;
      3: sh = 16;
      default: sh = 27;
    endcase
    case ($urandom_range(0, 3))
      0: b = 32'd0;
      1: b = 32'hFFFF_FFFF - 32'(10 << sh);
      2: b = $urandom_range(0, 255);
      default: b = $urandom;
    endcase
    for (int k = 0; k < BND_N; k++) begin
      send_beat(pci_pkg::OP_WR_BND, 4'(k), b, $urandom);
      b = b + $urandom_range(0, 1 << sh);
    end
  endtask

  task automatic load_cal_words();
    int pick;
    pick = $urandom_range(0, 2);
    for (int k = 0; k < CAL_N; k++) begin
      if (pick != 2)
        send_beat(pci_pkg::OP_WR_HIGH, 4'(k), {16'($urandom), pick_word()}, $urandom);
      if (pick != 1)
        send_beat(pci_pkg::OP_WR_LOW, 4'(k), {16'($urandom), pick_word()}, $urandom);
    end
  endtask

  // Stray writes: past the table ends, single boundaries that may break ordering, or single calibration words.
  task automatic send_noise();
    case ($urandom_range(0, 3))
      0: send_beat(pci_pkg::OP_WR_BND, 4'($urandom_range(BND_N, 15)), $urandom,
                   $urandom);
      1: send_beat($urandom_range(0, 1) ? pci_pkg::OP_WR_HIGH : pci_pkg::OP_WR_LOW,
                   4'($urandom_range(CAL_N, 15)), $urandom, $urandom);
      2: send_beat(pci_pkg::OP_WR_BND, 4'($urandom_range(0, BND_N - 1)), $urandom,
                   $urandom);
      default: send_beat($urandom_range(0, 1) ? pci_pkg::OP_WR_HIGH : pci_pkg::OP_WR_LOW,
                         4'($urandom_range(0, CAL_N - 1)), $urandom, $urandom);
    endcase
  endtask

  task automatic test_random_traffic();
    int start_items;
    int kind;
    start_items = loads_done + queries_done;
    while (loads_done + queries_done - start_items < RANDOM_ITEMS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      kind = $urandom_range(0, 9);
      if (kind < 2) load_ascending_bounds();
      else if (kind < 4) load_cal_words();
      else if (kind == 4) send_noise();
      else begin
        repeat ($urandom_range(4, 16))
          send_beat(pci_pkg::OP_QUERY, 4'($urandom), $urandom, pick_freq());
      end
      if ($urandom_range(0, 39) == 0) wait_for_results();
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_table_load();
    test_sector_edges();
    test_ignored_loads();
    test_drain_pause();
    test_random_traffic();
    in_valid <= 1'b0;
    do @(posedge clk); while (levels_due.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Run covered %0d table writes, %0d out-of-range writes, %0d lookups.",
             loads_done, loads_dropped, queries_done);
    $display("%0d level sets compared over %0d cycles.", results_seen, cycle_cnt);
    if (err_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/pci_pkg.sv
rtl/core/pci_ctrl.sv
rtl/core/pci_dp.sv
rtl/core/power_cal_interpolator.sv
tb/sv/tb.sv
